@@ sv/srre_pkg.sv @@
package srre_pkg;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 16;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 64;
  localparam int BCNT_W  = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_COUNT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_X     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_Y     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DATA  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TERM  = 3'd4;

  // register indexes (word address)
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_EMPTY_PIXEL  = 2'd2;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd1;
  localparam logic [PIX_W-1:0] EMPTY_RESET  = 8'd255;

  // one command from front to back: an optional closed run and an optional terminator
  typedef struct packed {
    logic             has_run;
    logic             term;
    logic             bank;
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] stop;
    logic [ROW_W-1:0] y;
  } cmd_t;

  // back tells front that a run store bank is free again
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

@@ sv/sparse_row_run_encoder.sv @@
// Channel   Direction  Handshake                      Payload
// pixel     in         push / full                    pixel_i
// result    out        empty / pop                    kind_o, value_o, byte_count_o, last_o
// config    in         psel, penable, pwrite / pready paddr, pwdata, prdata
//
// Pixels are taken one per cycle; full rises while the two-entry command queue is
// full or while the run store bank for the next run is still being read out.
// Count, x, y and terminator words leave one per cycle while pop keeps the output free;
// a data word is built by setup, one store read a cycle, return and output load.
// Reset clears counters, queue and the output valid flag; the run store needs no clearing.
// A stalled pop holds the output register; the front keeps taking pixels until full rises.
module sparse_row_run_encoder import srre_pkg::*; #(
  parameter int MAX_WIDTH        = 256,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [PIX_W-1:0]   pixel_i,
  output logic               empty,
  input  logic               pop,
  output logic [KIND_W-1:0]  kind_o,
  output logic [VALUE_W-1:0] value_o,
  output logic [BCNT_W-1:0]  byte_count_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int RAM_DEPTH = 2 * (1 << AW);

  logic [COL_W-1:0] image_width_q;
  logic [ROW_W-1:0] image_height_q;
  logic [PIX_W-1:0] empty_pixel_q;
  logic             cfg_wr;

  logic      q_full, q_empty, q_push, q_pop;
  cmd_t      q_cmd_in, q_cmd_out;
  bank_rel_t rel;
  logic      wr_en;
  logic [AW:0] wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
      empty_pixel_q  <= EMPTY_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[COL_W-1:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[ROW_W-1:0];
        REG_EMPTY_PIXEL:  empty_pixel_q  <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_q);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_q);
      REG_EMPTY_PIXEL:  prdata = DATA_W'(empty_pixel_q);
      default:          prdata = '0;
    endcase
  end

  srre_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .pixel_i        (pixel_i),
    .full_o         (full),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .empty_pixel_i  (empty_pixel_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_cmd_in),
    .rel_i          (rel),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  srre_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out),
    .empty_o (q_empty)
  );

  srre_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_run_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  srre_back #(
    .MAX_WIDTH        (MAX_WIDTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_cmd_i      (q_cmd_out),
    .q_pop_o      (q_pop),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .rel_o        (rel),
    .pop_i        (pop),
    .empty_o      (empty),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );

endmodule

@@ sv/srre_ram.sv @@
module srre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/srre_front.sv @@
module srre_front import srre_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [PIX_W-1:0]           pixel_i,
  output logic                       full_o,
  input  logic [COL_W-1:0]           image_width_i,
  input  logic [ROW_W-1:0]           image_height_i,
  input  logic [PIX_W-1:0]           empty_pixel_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output cmd_t                       q_cmd_o,
  input  bank_rel_t                  rel_i,
  output logic                       wr_en_o,
  output logic [$clog2(MAX_WIDTH):0] wr_addr_o,
  output logic [PIX_W-1:0]           wr_data_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [COL_W-1:0] column_q, column_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             run_active_q, run_active_d;
  logic [COL_W-1:0] run_start_q, run_start_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] col;
  logic             accept;
  logic             is_empty;
  logic             close_empty;
  logic             close_row;
  logic             row_end;
  logic             img_end;
  logic [COL_W-1:0] new_start;

  always_comb begin
    if (image_width_i == '0) begin
      w_eff = COL_W'(1);
    end else if (image_width_i > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width_i;
    end
    h_eff = (image_height_i == '0) ? ROW_W'(1) : image_height_i;
  end

  // column is pulled back when the width shrank mid-image
  assign col       = (column_q >= w_eff) ? w_eff - COL_W'(1) : column_q;
  assign is_empty  = (pixel_i == empty_pixel_i);
  assign row_end   = ((COL_W+1)'(col) + (COL_W+1)'(1)) >= (COL_W+1)'(w_eff);
  assign img_end   = row_end && (((ROW_W+1)'(row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff));
  assign new_start = run_active_q ? run_start_q : col;

  assign close_empty = is_empty && run_active_q;
  assign close_row   = row_end && !is_empty;

  assign full_o = q_full_i || busy_q[bank_q];
  assign accept = push_i && !full_o;

  always_comb begin
    q_cmd_o.has_run = close_empty || close_row;
    q_cmd_o.term    = img_end;
    q_cmd_o.bank    = bank_q;
    q_cmd_o.start   = close_empty ? run_start_q : new_start;
    q_cmd_o.stop    = close_empty ? col : w_eff;
    q_cmd_o.y       = row_q;
  end

  assign q_push_o  = accept && (q_cmd_o.has_run || q_cmd_o.term);
  assign wr_en_o   = accept && !is_empty;
  assign wr_addr_o = {bank_q, col[AW-1:0]};
  assign wr_data_o = pixel_i;

  always_comb begin
    column_d     = column_q;
    row_d        = row_q;
    run_active_d = run_active_q;
    run_start_d  = run_start_q;
    bank_d       = bank_q;
    busy_d       = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      run_active_d = !is_empty && !row_end;
      run_start_d  = new_start;
      if (q_cmd_o.has_run) begin
        busy_d[bank_q] = 1'b1;
        bank_d         = !bank_q;
      end
      if (row_end) begin
        column_d = '0;
        row_d    = img_end ? '0 : row_q + ROW_W'(1);
      end else begin
        column_d = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      row_q        <= '0;
      run_active_q <= 1'b0;
      run_start_q  <= '0;
      bank_q       <= 1'b0;
      busy_q       <= '0;
    end else begin
      column_q     <= column_d;
      row_q        <= row_d;
      run_active_q <= run_active_d;
      run_start_q  <= run_start_d;
      bank_q       <= bank_d;
      busy_q       <= busy_d;
    end
  end

endmodule

@@ sv/srre_cmd_fifo.sv @@
module srre_cmd_fifo import srre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = ent_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ sv/srre_back.sv @@
module srre_back import srre_pkg::*; #(
  parameter int MAX_WIDTH        = 256,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  cmd_t                       q_cmd_i,
  output logic                       q_pop_o,
  output logic [$clog2(MAX_WIDTH):0] rd_addr_o,
  input  logic [PIX_W-1:0]           rd_data_i,
  output bank_rel_t                  rel_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [KIND_W-1:0]          kind_o,
  output logic [VALUE_W-1:0]         value_o,
  output logic [BCNT_W-1:0]          byte_count_o,
  output logic                       last_o
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int BPR = BYTES_PER_RESULT;
  localparam int PW  = BPR * PIX_W;
  localparam int KW  = $clog2(BPR + 1);
  localparam int LW  = (BPR > 1) ? $clog2(BPR) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CNT   = 3'd1;
  localparam logic [2:0] S_X     = 3'd2;
  localparam logic [2:0] S_Y     = 3'd3;
  localparam logic [2:0] S_WSET  = 3'd4;
  localparam logic [2:0] S_DATA  = 3'd5;
  localparam logic [2:0] S_DEMIT = 3'd6;
  localparam logic [2:0] S_T1    = 3'd7;

  logic [2:0]       state_q, state_d;
  logic             term2_q, term2_d;
  cmd_t             cmd_q, cmd_d;
  logic [COL_W-1:0] p_q, p_d;
  logic [KW-1:0]    k_q, k_d;
  logic [KW-1:0]    g_q, g_d;
  logic [KW-1:0]    wlen_q, wlen_d;
  logic [PW-1:0]    pack_q, pack_d;
  logic             rvalid_q, rvalid_d;
  logic [LW-1:0]    rlane_q, rlane_d;

  logic                out_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [VALUE_W-1:0]  value_q;
  logic [BCNT_W-1:0]   bcnt_q;
  logic                last_q;

  logic                out_ld_ok;
  logic                ld;
  logic [KIND_W-1:0]   ld_kind;
  logic [VALUE_W-1:0]  ld_value;
  logic [BCNT_W-1:0]   ld_cnt;
  logic                ld_last;

  logic [COL_W-1:0] rem;
  logic             has_data;
  logic [31:0]      cnt_word;

  assign out_ld_ok = !out_valid_q || pop_i;
  assign rem       = cmd_q.stop - p_q;
  assign has_data  = cmd_q.stop > cmd_q.start;
  // count word wraps like a 32-bit difference when the run start lies past its end
  assign cnt_word  = {{(32-COL_W){1'b0}}, cmd_q.stop} - {{(32-COL_W){1'b0}}, cmd_q.start};
  assign rd_addr_o = {cmd_q.bank, p_q[AW-1:0]};

  always_comb begin
    state_d   = state_q;
    term2_d   = term2_q;
    cmd_d     = cmd_q;
    p_d       = p_q;
    k_d       = k_q;
    g_d       = g_q;
    wlen_d    = wlen_q;
    pack_d    = pack_q;
    rvalid_d  = 1'b0;
    rlane_d   = rlane_q;
    ld        = 1'b0;
    ld_kind   = KIND_COUNT;
    ld_value  = '0;
    ld_cnt    = '0;
    ld_last   = 1'b0;
    q_pop_o   = 1'b0;
    rel_o     = '0;
    rel_o.bank = cmd_q.bank;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          term2_d = 1'b0;
          state_d = q_cmd_i.has_run ? S_CNT : S_T1;
        end
      end
      S_CNT: begin
        if (out_ld_ok) begin
          ld       = 1'b1;
          ld_kind  = KIND_COUNT;
          ld_value = VALUE_W'(cnt_word);
          state_d  = S_X;
        end
      end
      S_X: begin
        if (out_ld_ok) begin
          ld       = 1'b1;
          ld_kind  = KIND_X;
          ld_value = VALUE_W'(cmd_q.start);
          state_d  = S_Y;
        end
      end
      S_Y: begin
        if (out_ld_ok) begin
          ld       = 1'b1;
          ld_kind  = KIND_Y;
          ld_value = VALUE_W'(cmd_q.y);
          ld_last  = !has_data && !cmd_q.term;
          if (has_data) begin
            p_d     = cmd_q.start;
            state_d = S_WSET;
          end else begin
            rel_o.valid = 1'b1;
            state_d     = cmd_q.term ? S_T1 : S_IDLE;
          end
        end
      end
      S_WSET: begin
        wlen_d  = (rem > COL_W'(BPR)) ? KW'(BPR) : KW'(rem);
        k_d     = '0;
        g_d     = '0;
        pack_d  = '0;
        state_d = S_DATA;
      end
      S_DATA: begin
        // one byte read issued per cycle, its data lands in the next cycle
        if (k_q < wlen_q) begin
          rvalid_d = 1'b1;
          rlane_d  = k_q[LW-1:0];
          p_d      = p_q + COL_W'(1);
          k_d      = k_q + KW'(1);
        end
        if (rvalid_q) begin
          pack_d[rlane_q*PIX_W +: PIX_W] = rd_data_i;
          g_d = g_q + KW'(1);
          if ((g_q + KW'(1)) == wlen_q) begin
            state_d = S_DEMIT;
          end
        end
      end
      S_DEMIT: begin
        if (out_ld_ok) begin
          ld       = 1'b1;
          ld_kind  = KIND_DATA;
          ld_value = VALUE_W'(pack_q);
          ld_cnt   = BCNT_W'(wlen_q);
          ld_last  = (p_q == cmd_q.stop) && !cmd_q.term;
          if (p_q == cmd_q.stop) begin
            rel_o.valid = 1'b1;
            state_d     = cmd_q.term ? S_T1 : S_IDLE;
          end else begin
            state_d = S_WSET;
          end
        end
      end
      S_T1: begin
        // two terminator words; term2 marks the second
        if (out_ld_ok) begin
          ld      = 1'b1;
          ld_kind = KIND_TERM;
          ld_last = term2_q;
          term2_d = !term2_q;
          state_d = term2_q ? S_IDLE : S_T1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      term2_q     <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      term2_q  <= term2_d;
      rvalid_q <= rvalid_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    p_q     <= p_d;
    k_q     <= k_d;
    g_q     <= g_d;
    wlen_q  <= wlen_d;
    pack_q  <= pack_d;
    rlane_q <= rlane_d;
    if (ld) begin
      kind_q  <= ld_kind;
      value_q <= ld_value;
      bcnt_q  <= ld_cnt;
      last_q  <= ld_last;
    end
  end

  assign empty_o      = !out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign byte_count_o = bcnt_q;
  assign last_o       = last_q;

endmodule

@@ sv/srre_checker.sv @@
module srre_checker import srre_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic [KIND_W-1:0] kind_o,
  input logic [BCNT_W-1:0] byte_count_o,
  input logic              last_o
);

  // only data results carry a byte count, and then a nonzero one
  a_bcnt_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((kind_o == KIND_DATA) == (byte_count_o != '0)))
    else $error("byte_count does not match result kind");

  // a run header is never the end of a request's results
  a_count_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_COUNT) |-> !last_o)
    else $error("count word flagged last");

  a_count_then_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && kind_o == KIND_COUNT) |=> (!empty && kind_o == KIND_X))
    else $error("x word does not follow count word");

  a_x_then_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && kind_o == KIND_X) |=> (!empty && kind_o == KIND_Y))
    else $error("y word does not follow x word");

endmodule

bind sparse_row_run_encoder srre_checker u_srre_checker (.*);
